FILE: src/bpa_pkg.sv
// Shared constants, status codes and helper functions for the buddy page allocator.
package bpa_pkg;

  // Default pool geometry.
  localparam int DEF_POOL_PAGES = 1024;
  localparam int DEF_MAX_ORDER  = 10;

  // Field widths of the item channels and the configuration port.
  localparam int REQ_W  = 11;
  localparam int OFF_W  = 10;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 4;

  // Width of an order value and of one block map entry.
  localparam int ORD_W = 5;
  localparam int ENT_W = 5;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

  // Log2 of the smallest power of two not below n, for n of one or more.
  function automatic logic [ORD_W-1:0] round_log(input logic [REQ_W-1:0] n);
    logic [REQ_W-1:0] m;
    logic [ORD_W-1:0] r;
    m = n - REQ_W'(1);
    r = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (m[i]) begin
        r = ORD_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/bpa_if.sv
// Request and result channel interfaces of the buddy page allocator.
interface bpa_in_if
  import bpa_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [REQ_W-1:0] request_pages;
  logic [OFF_W-1:0] block_offset;

  modport source (output valid, req_type, request_pages, block_offset, input ready);
  modport sink   (input valid, req_type, request_pages, block_offset, output ready);
endinterface

interface bpa_out_if
  import bpa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  granted_offset;
  logic [REQ_W-1:0]  granted_pages;
  logic [REQ_W-1:0]  avail_pages;

  modport source (output valid, status, granted_offset, granted_pages, avail_pages,
                  input ready);
  modport sink   (input valid, status, granted_offset, granted_pages, avail_pages,
                  output ready);
endinterface

FILE: src/bpa_mem.sv
// Block map memory: one write port, one read port with registered read data.
module bpa_mem
  import bpa_pkg::*;
#(
  parameter int DEPTH = DEF_POOL_PAGES,
  parameter int AW    = $clog2(DEF_POOL_PAGES)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bpa_ctrl.sv
// Sequencer of the buddy allocator: clearing, scan, split and merge over the block map.
module bpa_ctrl
  import bpa_pkg::*;
#(
  parameter int POOL_PAGES = DEF_POOL_PAGES,
  parameter int MAX_ORDER  = DEF_MAX_ORDER,
  parameter int AW         = $clog2(DEF_POOL_PAGES)
) (
  input  logic             clk,
  input  logic             rst_n,
  bpa_in_if.sink           in_req,
  bpa_out_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [ENT_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [ENT_W-1:0] mem_rdata
);

  localparam int CW       = $clog2(POOL_PAGES + 1);
  localparam int WW       = ((CW > REQ_W) ? CW : REQ_W) + 1;
  localparam int PLOG_MAX = $clog2(POOL_PAGES + 1) - 1;
  localparam int RST_LOG  = (MAX_ORDER < PLOG_MAX) ? MAX_ORDER : PLOG_MAX;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SPLIT, S_MREAD, S_MCHK, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [ORD_W-1:0]  pool_log_r, pool_log_nxt;
  logic [CW-1:0]     free_cnt_r, free_cnt_nxt;
  logic [AW-1:0]     clr_a_r, clr_a_nxt;
  logic              typ_r, typ_nxt;
  logic [ORD_W-1:0]  need_r, need_nxt;
  logic [AW-1:0]     off_r, off_nxt;
  logic [AW-1:0]     rd_a_r, rd_a_nxt;
  logic              iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_a_r, pend_a_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_r, best_nxt;
  logic [ORD_W-1:0]  best_ord_r, best_ord_nxt;
  logic              ovl_r, ovl_nxt;
  logic [ORD_W-1:0]  cur_ord_r, cur_ord_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [REQ_W-1:0]  res_pg_r, res_pg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [REQ_W-1:0]  out_pg_r, out_pg_nxt;
  logic [REQ_W-1:0]  out_free_r, out_free_nxt;

  logic [ORD_W-1:0]  cfg_log;
  logic [ORD_W-1:0]  in_need;
  logic [WW-1:0]     pool_size_w, pool_size_m1, in_size_w, in_off_w;
  logic              in_bad;
  logic [AW-1:0]     last_a;
  logic [ORD_W-1:0]  c_ord;
  logic [WW-1:0]     h_w, len_w, off_w, size_w, off_end_w, split_a_w, best_w, free_w;
  logic              cand_ok, ovl_hit;
  logic              f_n, o_n;
  logic [AW-1:0]     b_n;
  logic [ORD_W-1:0]  bo_n;
  logic [ORD_W-1:0]  ord_m1;
  logic [AW-1:0]     buddy_a;
  logic              in_ready;

  // Effective pool order of a configuration write.
  always_comb begin
    cfg_log = ORD_W'(cfg_wdata);
    if (cfg_log > ORD_W'(MAX_ORDER)) begin
      cfg_log = ORD_W'(MAX_ORDER);
    end
    if (cfg_log > ORD_W'(PLOG_MAX)) begin
      cfg_log = ORD_W'(PLOG_MAX);
    end
  end

  // Request checks that need no memory access.
  assign in_need      = round_log(in_req.request_pages);
  assign pool_size_w  = WW'(1) << pool_log_r;
  assign pool_size_m1 = pool_size_w - WW'(1);
  assign last_a       = pool_size_m1[AW-1:0];
  assign in_size_w    = WW'(1) << in_need;
  assign in_off_w     = WW'(in_req.block_offset);
  assign in_bad = (in_req.request_pages == '0) || (in_need > pool_log_r) ||
                  ((in_req.req_type == REQ_FREE) &&
                   (((in_off_w & (in_size_w - WW'(1))) != '0) ||
                    (in_off_w + in_size_w > pool_size_w)));

  // Scan datapath: fit test and overlap test on the entry just read.
  assign c_ord     = mem_rdata - ENT_W'(1);
  assign h_w       = WW'(pend_a_r);
  assign len_w     = WW'(1) << c_ord;
  assign off_w     = WW'(off_r);
  assign size_w    = WW'(1) << need_r;
  assign off_end_w = off_w + size_w;
  assign cand_ok   = (mem_rdata != '0) && (c_ord >= need_r) &&
                     (!found_r || (c_ord < best_ord_r));
  assign ovl_hit   = (mem_rdata != '0) && (h_w < off_end_w) && (off_w < h_w + len_w);
  assign f_n       = found_r | (pend_r & cand_ok);
  assign b_n       = (pend_r && cand_ok) ? pend_a_r : best_r;
  assign bo_n      = (pend_r && cand_ok) ? c_ord : best_ord_r;
  assign o_n       = ovl_r | (pend_r & ovl_hit);

  // Split and merge addresses.
  assign ord_m1    = cur_ord_r - ORD_W'(1);
  assign best_w    = WW'(best_r);
  assign split_a_w = best_w + (WW'(1) << ord_m1);
  assign buddy_a   = head_r ^ AW'(WW'(1) << cur_ord_r);
  assign free_w    = WW'(free_cnt_r);

  assign in_ready      = (state_r == S_IDLE) && !cfg_we;
  assign in_req.ready  = in_ready;

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_st_r;
  assign out_rsp.granted_offset = out_off_r;
  assign out_rsp.granted_pages  = out_pg_r;
  assign out_rsp.avail_pages    = out_free_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt    = state_r;
    pool_log_nxt = pool_log_r;
    free_cnt_nxt = free_cnt_r;
    clr_a_nxt    = clr_a_r;
    typ_nxt      = typ_r;
    need_nxt     = need_r;
    off_nxt      = off_r;
    rd_a_nxt     = rd_a_r;
    iss_nxt      = iss_r;
    pend_nxt     = 1'b0;
    pend_a_nxt   = pend_a_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_ord_nxt = best_ord_r;
    ovl_nxt      = ovl_r;
    cur_ord_nxt  = cur_ord_r;
    head_nxt     = head_r;
    res_st_nxt   = res_st_r;
    res_off_nxt  = res_off_r;
    res_pg_nxt   = res_pg_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_st_nxt   = out_st_r;
    out_off_nxt  = out_off_r;
    out_pg_nxt   = out_pg_r;
    out_free_nxt = out_free_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_r)
      // Sweep the whole map, leaving one free block of pool size at entry zero.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_a_r;
        mem_wdata = (clr_a_r == '0) ? ENT_W'(pool_log_r + ORD_W'(1)) : '0;
        clr_a_nxt = clr_a_r + AW'(1);
        if (clr_a_r == AW'(POOL_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request; malformed ones are answered without touching the map.
      S_IDLE: begin
        if (in_req.valid && in_ready) begin
          typ_nxt  = in_req.req_type;
          need_nxt = in_need;
          off_nxt  = in_off_w[AW-1:0];
          if (in_bad) begin
            res_st_nxt  = ST_BAD;
            res_off_nxt = '0;
            res_pg_nxt  = '0;
            state_nxt   = S_DONE;
          end else begin
            rd_a_nxt  = '0;
            iss_nxt   = 1'b1;
            found_nxt = 1'b0;
            ovl_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      // Read every entry of the pool once, one per cycle.
      S_SCAN: begin
        if (iss_r) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_a_r;
          pend_nxt   = 1'b1;
          pend_a_nxt = rd_a_r;
          rd_a_nxt   = rd_a_r + AW'(1);
          if (rd_a_r == last_a) begin
            iss_nxt = 1'b0;
          end
        end
        found_nxt    = f_n;
        best_nxt     = b_n;
        best_ord_nxt = bo_n;
        ovl_nxt      = o_n;
        if (pend_r && (pend_a_r == last_a)) begin
          if (typ_r == REQ_ALLOC) begin
            if (!f_n) begin
              res_st_nxt  = ST_NOFIT;
              res_off_nxt = '0;
              res_pg_nxt  = '0;
              state_nxt   = S_DONE;
            end else begin
              cur_ord_nxt = bo_n;
              state_nxt   = S_SPLIT;
            end
          end else begin
            if (o_n) begin
              res_st_nxt  = ST_BAD;
              res_off_nxt = '0;
              res_pg_nxt  = '0;
              state_nxt   = S_DONE;
            end else begin
              free_cnt_nxt = free_cnt_r + size_w[CW-1:0];
              head_nxt     = off_r;
              cur_ord_nxt  = need_r;
              res_st_nxt   = ST_OK;
              res_off_nxt  = off_w[OFF_W-1:0];
              res_pg_nxt   = size_w[REQ_W-1:0];
              state_nxt    = S_MREAD;
            end
          end
        end
      end

      // Split the chosen block one order per cycle; upper halves go free.
      S_SPLIT: begin
        mem_we = 1'b1;
        if (cur_ord_r > need_r) begin
          mem_waddr   = split_a_w[AW-1:0];
          mem_wdata   = ENT_W'(cur_ord_r);
          cur_ord_nxt = ord_m1;
        end else begin
          mem_waddr    = best_r;
          mem_wdata    = '0;
          free_cnt_nxt = free_cnt_r - size_w[CW-1:0];
          res_st_nxt   = ST_OK;
          res_off_nxt  = best_w[OFF_W-1:0];
          res_pg_nxt   = size_w[REQ_W-1:0];
          state_nxt    = S_DONE;
        end
      end

      // Read the buddy, or store the merged block once it spans the whole pool.
      S_MREAD: begin
        if (cur_ord_r < pool_log_r) begin
          mem_re    = 1'b1;
          mem_raddr = buddy_a;
          state_nxt = S_MCHK;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = ENT_W'(cur_ord_r + ORD_W'(1));
          state_nxt = S_DONE;
        end
      end

      // Merge with a free buddy of equal size, or store the block as it is.
      S_MCHK: begin
        mem_we = 1'b1;
        if (mem_rdata == ENT_W'(cur_ord_r + ORD_W'(1))) begin
          mem_waddr   = buddy_a;
          mem_wdata   = '0;
          cur_ord_nxt = cur_ord_r + ORD_W'(1);
          if (buddy_a < head_r) begin
            head_nxt = buddy_a;
          end
          state_nxt = S_MREAD;
        end else begin
          mem_waddr = head_r;
          mem_wdata = ENT_W'(cur_ord_r + ORD_W'(1));
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_off_nxt   = res_off_r;
          out_pg_nxt    = res_pg_r;
          out_free_nxt  = free_w[REQ_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        clr_a_nxt = '0;
      end
    endcase

    // A new pool size rebuilds the map from scratch.
    if (cfg_we) begin
      pool_log_nxt = cfg_log;
      free_cnt_nxt = CW'(1) << cfg_log;
      clr_a_nxt    = '0;
      state_nxt    = S_CLEAR;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pool_log_r  <= ORD_W'(RST_LOG);
      free_cnt_r  <= CW'(1) << RST_LOG;
      clr_a_r     <= '0;
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_log_r  <= pool_log_nxt;
      free_cnt_r  <= free_cnt_nxt;
      clr_a_r     <= clr_a_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    typ_r      <= typ_nxt;
    need_r     <= need_nxt;
    off_r      <= off_nxt;
    rd_a_r     <= rd_a_nxt;
    pend_a_r   <= pend_a_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    best_ord_r <= best_ord_nxt;
    ovl_r      <= ovl_nxt;
    cur_ord_r  <= cur_ord_nxt;
    head_r     <= head_nxt;
    res_st_r   <= res_st_nxt;
    res_off_r  <= res_off_nxt;
    res_pg_r   <= res_pg_nxt;
    out_st_r   <= out_st_nxt;
    out_off_r  <= out_off_nxt;
    out_pg_r   <= out_pg_nxt;
    out_free_r <= out_free_nxt;
  end

  // The free count never exceeds the pool.
  a_free_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
    free_w <= pool_size_w)
    else $error("free page count exceeds pool size");

  // Splitting never goes below the requested order.
  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (cur_ord_r >= need_r))
    else $error("split went below requested order");

  // A failed request reports neither offset nor size.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_OK)) |-> ((out_off_r == '0) && (out_pg_r == '0)))
    else $error("failed request reports a grant");

  // A buddy check always follows its buddy read.
  a_mchk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MCHK) |-> ($past(state_r) == S_MREAD))
    else $error("buddy check without buddy read");

endmodule

FILE: src/buddy_page_allocator.sv
// Buddy page allocator: block map memory plus its sequencer.
// Malformed requests go straight to the result; others first scan the block map (one entry
// per cycle), then a granted block is split or a freed one merged with its free buddies,
// and the result then moves to the output register.
// One item is in work at a time; the next is taken while a result waits to be read.
// Reset and every pool_order write clear the whole map; no item is taken then.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int POOL_PAGES = DEF_POOL_PAGES,
  parameter int MAX_ORDER  = DEF_MAX_ORDER
) (
  input  logic             clk,
  input  logic             rst_n,
  bpa_in_if.sink           in_req,
  bpa_out_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(POOL_PAGES);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  // Sequencer.
  bpa_ctrl #(
    .POOL_PAGES (POOL_PAGES),
    .MAX_ORDER  (MAX_ORDER),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Block map.
  bpa_mem #(
    .DEPTH (POOL_PAGES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: tb/sv/bpa_tb_if.sv
// Configuration port interface that the testbench drives and the checker watches.
`timescale 1ns / 100ps
interface bpa_cfg_if
  import bpa_pkg::*;
  ();
  logic             we;
  logic [CFG_W-1:0] wdata;

  modport source (output we, wdata);
  modport sink   (input we, wdata);
endinterface

FILE: tb/sv/bpa_checker.sv
// Checker that predicts buddy allocator results and compares them with the outputs.
`timescale 1ns / 100ps
module bpa_checker
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bpa_in_if.sink     req_mon,
  bpa_out_if.sink    rsp_mon,
  bpa_cfg_if.sink    cfg_mon,
  output int         err_count,
  output int         pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  offset;
    logic [REQ_W-1:0]  pages;
    logic [REQ_W-1:0]  avail_pages;
  } grant_t;

  logic [ENT_W-1:0] heads [DEF_POOL_PAGES];
  int unsigned      pool_sz;
  int unsigned      pool_lg;
  int unsigned      pages_free;
  grant_t           grant_q [$];

  // Rebuild the pool as one free block.
  function automatic void init_pool(input logic [CFG_W-1:0] ord);
    int unsigned k;
    k = (ord > DEF_MAX_ORDER) ? DEF_MAX_ORDER : ord;
    while (k > 0 && (1 << k) > DEF_POOL_PAGES) k--;
    pool_lg = k;
    pool_sz = 1 << k;
    foreach (heads[i]) heads[i] = '0;
    heads[0] = ENT_W'(k + 1);
    pages_free = pool_sz;
  endfunction

  function automatic int unsigned ceil_log(input int unsigned n);
    int unsigned j;
    j = 0;
    while ((1 << j) < n) j++;
    return j;
  endfunction

  function automatic bit hits_free(input int unsigned off, input int unsigned sz);
    int unsigned len;
    for (int unsigned h = 0; h < pool_sz; h++) begin
      if (heads[h] != 0) begin
        len = 1 << (heads[h] - 1);
        if (h < off + sz && off < h + len) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the predicted block map and return the expected grant.
  function automatic grant_t serve_request(input logic kind, input int unsigned req,
                                           input int unsigned off);
    grant_t g;
    int unsigned need, sz, best, best_ord, head, ord, bud;
    bit found;
    g = '0;
    g.status = ST_BAD;
    if (req != 0) begin
      need = ceil_log(req);
      if (need <= pool_lg) begin
        sz = 1 << need;
        if (kind == REQ_ALLOC) begin
          found = 1'b0;
          best = 0;
          best_ord = 0;
          for (int unsigned h = 0; h < pool_sz; h++) begin
            if (heads[h] != 0 && heads[h] - 1 >= need && (!found || heads[h] - 1 < best_ord))
            begin
              found = 1'b1;
              best = h;
              best_ord = heads[h] - 1;
            end
          end
          if (!found) begin
            g.status = ST_NOFIT;
          end else begin
            while (best_ord > need) begin
              best_ord--;
              heads[best + (1 << best_ord)] = ENT_W'(best_ord + 1);
            end
            heads[best] = '0;
            pages_free -= sz;
            g.status = ST_OK;
            g.offset = OFF_W'(best);
            g.pages = REQ_W'(sz);
          end
        end else if ((off & (sz - 1)) == 0 && off + sz <= pool_sz && !hits_free(off, sz)) begin
          head = off;
          ord = need;
          pages_free += sz;
          while (ord < pool_lg) begin
            bud = head ^ (1 << ord);
            if (heads[bud] != ord + 1) break;
            heads[bud] = '0;
            if (bud < head) head = bud;
            ord++;
          end
          heads[head] = ENT_W'(ord + 1);
          g.status = ST_OK;
          g.offset = OFF_W'(off);
          g.pages = REQ_W'(sz);
        end
      end
    end
    g.avail_pages = REQ_W'(pages_free);
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  assign pending = grant_q.size();

  // Track configuration, predict on each accepted item and compare each result.
  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      init_pool(CFG_W'(DEF_MAX_ORDER));
      grant_q.delete();
      err_count = 0;
    end else begin
      if (cfg_mon.we) init_pool(cfg_mon.wdata);
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("results outstanding", 1, 0);
        end else begin
          g = grant_q.pop_front();
          if (rsp_mon.status !== g.status) report_mismatch("status", rsp_mon.status, g.status);
          if (rsp_mon.granted_offset !== g.offset)
            report_mismatch("granted_offset", rsp_mon.granted_offset, g.offset);
          if (rsp_mon.granted_pages !== g.pages)
            report_mismatch("granted_pages", rsp_mon.granted_pages, g.pages);
          if (rsp_mon.avail_pages !== g.avail_pages)
            report_mismatch("avail_pages", rsp_mon.avail_pages, g.avail_pages);
        end
      end
      if (req_mon.valid && req_mon.ready)
        grant_q.push_back(serve_request(req_mon.req_type, req_mon.request_pages,
                                        req_mon.block_offset));
    end
  end

endmodule

FILE: tb/sv/tb_buddy_page_allocator.sv
// Top of the buddy page allocator testbench: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_buddy_page_allocator;
  import bpa_pkg::*;

  localparam int WATCH_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_count;
  int   pending;
  int   idle_cycles = 0;
  bit   no_idle;
  bit   hold_off;

  bpa_in_if  req_ch ();
  bpa_out_if rsp_ch ();
  bpa_cfg_if cfg_ch ();

  // Allocated request sizes; a random free is sent only once one is held.
  int unsigned held_off_q [$];
  int unsigned held_sz_q [$];
  int unsigned pool_now;

  always #2 clk = ~clk;

  buddy_page_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch.sink),
    .out_rsp  (rsp_ch.source),
    .cfg_we   (cfg_ch.we),
    .cfg_wdata(cfg_ch.wdata)
  );

  bpa_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_mon  (req_ch.sink),
    .rsp_mon  (rsp_ch.sink),
    .cfg_mon  (cfg_ch.sink),
    .err_count(err_count),
    .pending  (pending)
  );

  // Send one item, with an optional burst of idle cycles first.
  task automatic send_item(input logic kind, input int unsigned pages, input int unsigned off);
    if (!no_idle && $urandom_range(3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.request_pages <= REQ_W'(pages);
    req_ch.block_offset  <= OFF_W'(off);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // Record the allocation, at offset zero, for the random request choice.
    if (kind == REQ_ALLOC && pages != 0) begin
      held_off_q.push_back(0);
      held_sz_q.push_back(pages);
    end
  endtask

  // Wait until the block is idle, then write the pool order.
  task automatic set_pool(input int unsigned ord);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * DEF_POOL_PAGES + 40) @(posedge clk);
    cfg_ch.we    <= 1'b1;
    cfg_ch.wdata <= CFG_W'(ord);
    @(posedge clk);
    cfg_ch.we <= 1'b0;
    pool_now = 1 << ((ord > DEF_MAX_ORDER) ? DEF_MAX_ORDER : ord);
    held_off_q.delete();
    held_sz_q.delete();
  endtask

  // Receiver: random stalls, plus a long hold-off requested by the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_off) begin
      rsp_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(5) == 0) begin
      rsp_ch.ready <= 1'b0;
      repeat ($urandom_range(17, 1) - 1) @(posedge clk);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_ch.we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random request: allocations, aligned frees of random blocks, and some malformed noise.
  task automatic random_request();
    int unsigned pick, sz, off;
    pick = $urandom_range(9);
    if (pick < 4 || held_sz_q.size() == 0) begin
      sz = (pick == 0) ? $urandom_range(2047) : $urandom_range(pool_now < 64 ? pool_now : 64);
      send_item(REQ_ALLOC, sz, $urandom_range(1023));
    end else if (pick < 8) begin
      sz = 1 << $clog2(pool_now);
      sz = 1 << $urandom_range($clog2(pool_now) < 6 ? $clog2(pool_now) : 6);
      off = $urandom_range(pool_now / sz - 1) * sz;
      send_item(REQ_FREE, sz - $urandom_range(sz / 2), off);
    end else begin
      send_item(REQ_FREE, $urandom_range(2047), $urandom_range(1023));
    end
  endtask

  initial begin
    no_idle      = 1'b0;
    hold_off     = 1'b0;
    pool_now     = DEF_POOL_PAGES;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ALLOC;
    req_ch.request_pages = '0;
    req_ch.block_offset  = '0;
    cfg_ch.we    = 1'b0;
    cfg_ch.wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation and each special case.
    send_item(REQ_ALLOC, 0, 0);
    send_item(REQ_FREE, 0, 0);
    send_item(REQ_ALLOC, 2047, 1023);
    send_item(REQ_ALLOC, 1024, 0);
    send_item(REQ_ALLOC, 1, 0);
    send_item(REQ_FREE, 1024, 0);
    send_item(REQ_FREE, 1, 0);
    send_item(REQ_FREE, 1, 0);
    send_item(REQ_ALLOC, 3, 0);
    send_item(REQ_ALLOC, 513, 0);
    send_item(REQ_FREE, 4, 2);
    send_item(REQ_FREE, 4, 1020);
    send_item(REQ_FREE, 4, 0);
    send_item(REQ_ALLOC, 512, 0);
    send_item(REQ_ALLOC, 512, 0);
    send_item(REQ_ALLOC, 1, 0);
    send_item(REQ_FREE, 512, 512);
    send_item(REQ_FREE, 512, 0);
    send_item(REQ_ALLOC, 1023, 0);

    // Long receiver hold-off so the block fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (6) random_request();
    join

    // Several pool sizes, the extremes among them.
    set_pool(0);
    repeat (20) random_request();
    set_pool(15);
    repeat (60) random_request();
    set_pool(1);
    repeat (30) random_request();
    set_pool(4);
    repeat (150) random_request();
    set_pool(10);
    repeat (200) random_request();
    no_idle = 1'b1;
    repeat (80) random_request();
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * DEF_POOL_PAGES + 40) @(posedge clk);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
